// ===== rtl/mjt_pkg.sv =====
// Minimum-jerk trajectory generator: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
package mjt_pkg;
    localparam logic [15:0] DUR_RESET = 16'd1000;
    localparam logic [6:0]  NPT_RESET = 7'd64;
    localparam logic [6:0]  NPT_LIMIT = 7'd64;
    localparam logic        CFG_DURATION = 1'b0;
    localparam logic        CFG_NUM_POINTS = 1'b1;

    typedef struct packed {
        logic signed [31:0] start_pos;
        logic        [32:0] mag;
        logic               neg;
        logic        [6:0]  n;
        logic        [15:0] dur;
    } t_job;
endpackage

// ===== rtl/minimum_jerk_trajectory_generator.sv =====
// Minimum-jerk trajectory generator top level: configuration registers,
// front end and back end. Depends on mjt_pkg, mjt_front, mjt_back.
//  channel | signals                          | flow
//  in      | i_valid/o_stall, start/target    | one item per joint move
//  out     | o_valid/i_stall, sample fields   | N items per move
//  cfg     | i_cfg_valid/o_cfg_ready, idx/data| register writes
// A sample takes three numerator steps, one multiply and three 96-bit serial
// divisions (position, velocity, time) on a shared divider. A move first
// passes through take and setup. Reset is synchronous, active low. A stalled
// output holds the next sample in the back end; the front holds one waiting item.
`timescale 1ns / 1ps
module minimum_jerk_trajectory_generator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [31:0]  i_start_pos,
    input  logic signed [31:0]  i_target_pos,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_position,
    output logic signed [31:0]  o_velocity,
    output logic [15:0]         o_time_ms,
    output logic [6:0]          o_point_index,
    output logic                o_last,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [0:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    logic [15:0]   r_dur;
    logic [6:0]    r_npt;
    logic          w_job_valid;
    logic          w_job_take;
    mjt_pkg::t_job w_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur <= mjt_pkg::DUR_RESET;
            r_npt <= mjt_pkg::NPT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mjt_pkg::CFG_DURATION:   r_dur <= i_cfg_data;
                mjt_pkg::CFG_NUM_POINTS: r_npt <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    mjt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_start_pos(i_start_pos), .i_target_pos(i_target_pos),
        .i_dur(r_dur), .i_npt(r_npt),
        .o_job_valid(w_job_valid), .o_job(w_job), .i_job_take(w_job_take)
    );

    mjt_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(w_job_valid), .i_job(w_job),
        .o_job_take(w_job_take), .o_valid(o_valid), .i_stall(i_stall),
        .o_position(o_position), .o_velocity(o_velocity), .o_time_ms(o_time_ms),
        .o_point_index(o_point_index), .o_last(o_last)
    );
endmodule

// ===== rtl/mjt_front.sv =====
// Front end: accepts an item, forms the signed difference and magnitude, and
// latches the configuration used for the move. Depends on mjt_pkg.
`timescale 1ns / 1ps
module mjt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [31:0]  i_start_pos,
    input  logic signed [31:0]  i_target_pos,
    input  logic [15:0]         i_dur,
    input  logic [6:0]          i_npt,
    output logic                o_job_valid,
    output mjt_pkg::t_job       o_job,
    input  logic                i_job_take
);
    logic          r_full;
    mjt_pkg::t_job r_job, n_job;
    logic signed [32:0] w_d;

    always_comb begin
        w_d = 33'(i_target_pos) - 33'(i_start_pos);
        n_job.start_pos = i_start_pos;
        n_job.neg = w_d[32];
        n_job.mag = w_d[32] ? 33'(-w_d) : 33'(w_d);
        n_job.n = (i_npt == 7'd0) ? 7'd1 : ((i_npt > mjt_pkg::NPT_LIMIT) ? mjt_pkg::NPT_LIMIT : i_npt);
        n_job.dur = (i_dur == 16'd0) ? 16'd1 : i_dur;
    end

    assign o_stall = r_full;
    assign o_job_valid = r_full;
    assign o_job = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_valid && !r_full) begin
            r_full <= 1'b1;
        end else if (i_job_take) begin
            r_full <= 1'b0;
        end
        if (i_valid && !r_full) begin
            r_job <= n_job;
        end
    end
endmodule

// ===== rtl/mjt_back.sv =====
// Back end: steps k = 1..N per job, computes one sample with a shared serial
// divider, and holds it in an output register. Depends on mjt_pkg.
`timescale 1ns / 1ps
module mjt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  mjt_pkg::t_job       i_job,
    output logic                o_job_take,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_position,
    output logic signed [31:0]  o_velocity,
    output logic [15:0]         o_time_ms,
    output logic [6:0]          o_point_index,
    output logic                o_last
);
    typedef enum logic [2:0] {
        S_IDLE, S_SETUP, S_NUM, S_MUL, S_DIVP, S_DIVV, S_DIVT, S_OUT
    } t_state;

    t_state        r_state;
    mjt_pkg::t_job r_job;
    logic [6:0]    r_k;
    logic [1:0]    r_phase;
    logic [13:0]   r_n2;
    logic [27:0]   r_n4;
    logic [30:0]   r_n5;
    logic [43:0]   r_vden;
    logic [47:0]   r_mag30k;
    logic [13:0]   r_k2;
    logic [13:0]   r_kn;
    logic [10:0]   r_knk;
    logic [18:0]   r_k3;
    logic [15:0]   r_poly;
    logic [20:0]   r_vk;
    logic [30:0]   r_pnum;
    logic [95:0]   r_dividend;
    logic [47:0]   r_den;
    logic [95:0]   r_rem;
    logic [95:0]   r_q;
    logic [6:0]    r_cnt;
    logic [32:0]   r_pmag;
    logic [95:0]   r_vmag;
    logic [96:0]   w_trial;
    logic [95:0]   w_shift;
    logic          w_qbit;
    logic          w_load;
    logic signed [34:0] w_pos;
    logic [32:0]   w_vm;
    logic [6:0]    w_nk;

    assign w_shift = {r_rem[94:0], r_dividend[95]};
    assign w_trial = {1'b0, w_shift} - {49'd0, r_den};
    assign w_qbit = !w_trial[96];
    assign w_nk = r_job.n - r_k;
    assign w_load = (r_state == S_OUT) && (!o_valid || !i_stall);
    assign o_job_take = (r_state == S_IDLE) && i_job_valid;

    always_comb begin
        w_pos = r_job.neg ? 35'($signed(r_job.start_pos)) - 35'(r_pmag)
                          : 35'($signed(r_job.start_pos)) + 35'(r_pmag);
        w_vm = (r_vmag > 96'h8000_0000) ? 33'h0_8000_0000 : r_vmag[32:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_load || (o_valid && i_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_k <= 7'd1;
                        r_n2 <= 14'(i_job.n) * 14'(i_job.n);
                        r_phase <= 2'd0;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    // per-move denominators and scaled magnitude
                    if (r_phase == 2'd0) begin
                        r_n4 <= 28'(r_n2) * 28'(r_n2);
                        r_mag30k <= 48'(r_job.mag) * 48'd30000;
                        r_phase <= 2'd1;
                    end else begin
                        r_n5 <= 31'(r_n4) * 31'(r_job.n);
                        r_vden <= 44'(r_n4) * 44'(r_job.dur);
                        r_phase <= 2'd0;
                        r_state <= S_NUM;
                    end
                end
                S_NUM: begin
                    // per-sample numerators
                    if (r_phase == 2'd0) begin
                        r_k2 <= 14'(r_k) * 14'(r_k);
                        r_kn <= 14'(r_k) * 14'(r_job.n);
                        r_knk <= 11'(14'(r_k) * 14'(w_nk));
                        r_phase <= 2'd1;
                    end else if (r_phase == 2'd1) begin
                        r_k3 <= 19'(r_k2) * 19'(r_k);
                        r_poly <= 16'(32'd10 * 32'(r_n2) + 32'd6 * 32'(r_k2)
                            - 32'd15 * 32'(r_kn));
                        r_vk <= 21'(r_knk) * 21'(r_knk);
                        r_phase <= 2'd2;
                    end else begin
                        r_pnum <= 31'(35'(r_k3) * 35'(r_poly));
                        r_phase <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_dividend <= 96'(r_job.mag) * 96'(r_pnum) + 96'(r_n5 >> 1);
                    r_den <= 48'(r_n5);
                    r_rem <= '0;
                    r_q <= '0;
                    r_cnt <= 7'd95;
                    r_state <= S_DIVP;
                end
                S_DIVP, S_DIVV, S_DIVT: begin
                    if (r_cnt != 7'd0) begin
                        r_dividend <= {r_dividend[94:0], 1'b0};
                        r_rem <= w_trial[96] ? w_shift : w_trial[95:0];
                        r_q <= {r_q[94:0], w_qbit};
                        r_cnt <= r_cnt - 7'd1;
                    end else if (r_state == S_DIVP) begin
                        r_pmag <= {r_q[31:0], w_qbit};
                        r_dividend <= 96'(r_mag30k) * 96'(r_vk) + 96'(r_vden >> 1);
                        r_den <= 48'(r_vden);
                        r_rem <= '0;
                        r_q <= '0;
                        r_cnt <= 7'd95;
                        r_state <= S_DIVV;
                    end else if (r_state == S_DIVV) begin
                        r_vmag <= {r_q[94:0], w_qbit};
                        r_dividend <= 96'(r_k) * 96'(r_job.dur);
                        r_den <= 48'(r_job.n);
                        r_rem <= '0;
                        r_q <= '0;
                        r_cnt <= 7'd95;
                        r_state <= S_DIVT;
                    end else begin
                        r_q <= {r_q[94:0], w_qbit};
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        o_position <= (w_pos > 35'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                            ((w_pos < -35'sh8000_0000) ? 32'sh8000_0000 : w_pos[31:0]);
                        o_velocity <= r_job.neg ? 32'(-w_vm) : ((w_vm[32] || w_vm[31])
                            ? 32'sh7FFF_FFFF : w_vm[31:0]);
                        o_time_ms <= r_q[15:0];
                        o_point_index <= r_k;
                        o_last <= (r_k == r_job.n);
                        if (r_k == r_job.n) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + 7'd1;
                            r_state <= S_NUM;
                        end
                    end
                end
            endcase
        end
    end
endmodule
